@@ rtl/core/ntc_pkg.sv @@
// Shared types, widths and constants for the NTC thermistor conversion pipeline.
// Used by ntc_log2 and ntc_thermistor_to_celsius; no dependencies.
`default_nettype none

package ntc_pkg;

	// input and configuration widths
	localparam int ADC_BITS_DEF = 14;
	localparam int RAW_W        = 14;
	localparam int RS_W         = 20;
	localparam int COEF_W       = 40;
	localparam int PADDR_W      = 5;
	localparam int PDATA_W      = 64;

	// log2 unit: 40-bit argument, Q32 result with 6-bit integer part
	localparam int LOG_XW  = 40;
	localparam int LOG_EW  = 6;
	localparam int FRAC_W  = 32;
	localparam int LOG_W   = LOG_EW + FRAC_W;
	localparam int LOG_LAT = FRAC_W + 2;

	// datapath widths after the log stage
	localparam int LNR_W   = 37;
	localparam int L2_W    = 42;
	localparam int L3_W    = 47;
	localparam int BT_W    = 45;
	localparam int CT_W    = 55;
	localparam int TERMS_W = 56;
	localparam int D_W     = 58;
	localparam int UD_W    = 57;
	localparam int Q_W     = 17;
	localparam int CMP_W   = UD_W + Q_W;
	localparam int TEMP_W  = 18;

	// register indexes
	localparam logic [1:0] REG_SERIES = 2'd0;
	localparam logic [1:0] REG_COEF_A = 2'd1;
	localparam logic [1:0] REG_COEF_B = 2'd2;
	localparam logic [1:0] REG_COEF_C = 2'd3;

	// register reset values
	localparam logic [RS_W-1:0]   RS_RESET     = 20'd10000;
	localparam logic [COEF_W-1:0] COEF_A_RESET = 40'd317826930000;
	localparam logic [COEF_W-1:0] COEF_B_RESET = 40'd65900330000;
	localparam logic [COEF_W-1:0] COEF_C_RESET = 40'd24678066;

	// ln 2 in Q32
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	// 100 * 2^48, dividend base for the temperature quotient
	localparam logic [UD_W-1:0] DIV_NUM = UD_W'(100) << 48;

	// output range in 0.01 C
	localparam logic [TEMP_W-1:0] T_MIN    = -18'sd27315;
	localparam logic [TEMP_W-1:0] T_MAX    = 18'sd100000;
	localparam logic [TEMP_W-1:0] T_OFFSET = 18'd27315;
	localparam logic [Q_W-1:0]    Q_MAX    = 17'd127315;

	// control flags that ride along the pipeline with each beat
	typedef struct packed {
		logic v;     // beat valid
		logic sp;    // zero code or zero series resistance
		logic neg;   // ln R is negative
		logic dz;    // denominator is zero
		logic dneg;  // denominator is negative
		logic ovf;   // quotient above the range
	} ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/ntc_log2.sv @@
// Pipelined log2 of a 40-bit unsigned value, Q32 result, 34 register stages.
// Depends on ntc_pkg; stalls through a shared enable.
`default_nettype none

module ntc_log2
	import ntc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [LOG_XW-1:0] x,
	output logic      [LOG_W-1:0]  y
);

	logic [LOG_XW-1:0] x_s1;
	logic [LOG_EW-1:0] e_s1;
	logic [LOG_EW-1:0] e_c;
	logic [LOG_XW-1:0] norm_c;

	logic [FRAC_W-1:0] man_s  [0:FRAC_W-1];
	logic [LOG_EW-1:0] exp_s  [0:FRAC_W];
	logic [FRAC_W-1:0] frac_s [1:FRAC_W];

	// msb position
	always_comb begin
		e_c = '0;
		for (int i = 0; i < LOG_XW; i++) begin
			if (x[i]) e_c = LOG_EW'(i);
		end
	end

	// stage 1: capture argument and exponent
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x;
			e_s1 <= e_c;
		end
	end

	// stage 2: normalize to a Q31 mantissa, truncating
	assign norm_c = x_s1 << (LOG_EW'(LOG_XW - 1) - e_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			man_s[0] <= norm_c[LOG_XW-1 -: FRAC_W];
			exp_s[0] <= e_s1;
		end
	end

	// one squaring step per stage, one fraction bit each
	for (genvar k = 1; k <= FRAC_W; k++) begin : g_sq
		logic [2*FRAC_W-1:0] sq;
		assign sq = (2*FRAC_W)'(man_s[k-1]) * (2*FRAC_W)'(man_s[k-1]);

		always_ff @(posedge clk) begin
			if (en) begin
				exp_s[k] <= exp_s[k-1];
			end
		end

		if (k < FRAC_W) begin : g_man
			always_ff @(posedge clk) begin
				if (en) begin
					man_s[k] <= sq[2*FRAC_W-1] ? sq[2*FRAC_W-1 -: FRAC_W]
					                           : sq[2*FRAC_W-2 -: FRAC_W];
				end
			end
		end

		if (k == 1) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					frac_s[k] <= {{(FRAC_W-1){1'b0}}, sq[2*FRAC_W-1]};
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					frac_s[k] <= {frac_s[k-1][FRAC_W-2:0], sq[2*FRAC_W-1]};
				end
			end
		end
	end

	assign y = {exp_s[FRAC_W], frac_s[FRAC_W]};

endmodule

`default_nettype wire

@@ rtl/core/ntc_thermistor_to_celsius.sv @@
// Top level: NTC thermistor ADC code to temperature in 0.01 C (Steinhart-Hart).
// Depends on ntc_pkg and ntc_log2.
//
// Usage:
//  - Input channel code_valid/code_stall/raw_code carries one ADC code per beat.
//  - Output channel temp_valid/temp_stall carries temp_centi_celsius and
//    saturated, one result beat per input beat, in order.
//  - APB port holds the series resistor and the A, B, C coefficients at byte
//    addresses 0, 8, 16, 24 (64-bit data); write them only while idle.
//  - Throughput: one beat per cycle while temp_stall does not hold the
//    pipeline. The pipeline spans the 32 squaring stages of each log2 unit
//    and the 17 restoring quotient stages of the divider.
//  - All stages advance together; when the result register is full and
//    temp_stall is high, the whole pipeline holds and code_stall is raised.
//  - Reset clears all valid bits and loads the register defaults
//    (10000 ohms and the stock coefficients).
`default_nettype none

module ntc_thermistor_to_celsius
	import ntc_pkg::*;
#(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [PADDR_W-1:0]        paddr,
	input  wire logic [PDATA_W-1:0]        pwdata,
	output logic      [PDATA_W-1:0]        prdata,
	output logic                           pready,
	input  wire logic                      code_valid,
	output logic                           code_stall,
	input  wire logic [RAW_W-1:0]          raw_code,
	output logic                           temp_valid,
	input  wire logic                      temp_stall,
	output logic signed [TEMP_W-1:0]       temp_centi_celsius,
	output logic                           saturated
);

	localparam int CW = ADC_BITS + 1;
	localparam int NW = RS_W + CW;
	localparam logic [CW-1:0] FULL_SCALE = CW'(1) << ADC_BITS;
	localparam logic [RAW_W-1:0] CODE_MASK = RAW_W'((33'd1 << ADC_BITS) - 33'd1);
	localparam int S_LOG = 36;
	localparam int S_OUT = 67;

	// configuration registers
	logic [RS_W-1:0]   series_q;
	logic [COEF_W-1:0] coef_a_q;
	logic [COEF_W-1:0] coef_b_q;
	logic [COEF_W-1:0] coef_c_q;

	logic en;

	// front stages
	logic [RAW_W-1:0]  code_m;
	logic              valid_s1, sp_s1, valid_s2, sp_s2;
	logic [RAW_W-1:0]  code_s1;
	logic [CW-1:0]     diff_c;
	logic [NW-1:0]     num_c;
	logic [LOG_XW-1:0] num_s2, den_s2;
	logic [LOG_LAT-1:0] v_dly_s, sp_dly_s;
	logic [LOG_W-1:0]  ln_num, ln_den;

	// control flags per stage
	ctl_t c36;
	ctl_t ctl_n [S_LOG+1:S_OUT];
	ctl_t ctl_s [S_LOG+1:S_OUT];

	// ln R and polynomial stages
	logic [LOG_W-1:0]   mag_s37;
	logic [LOG_W-1:0]   lnh_s38;
	logic [63:0]        lnl_s38;
	logic [LNR_W-1:0]   lnr_s39, lnr_s40, lnr_s41;
	logic [63:0]        sq_ll_s40;
	logic [LNR_W-1:0]   sq_lh_s40;
	logic [9:0]         sq_hh_s40;
	logic [63:0]        b_ll_s40;
	logic [LNR_W-1:0]   b_lh_s40;
	logic [39:0]        b_hl_s40;
	logic [12:0]        b_hh_s40;
	logic [L2_W-1:0]    l2_s41;
	logic [BT_W-1:0]    bt_s41, bt_s42, bt_s43, bt_s44, bt_s45;
	logic [63:0]        c_ll_s42;
	logic [LNR_W-1:0]   c_lh_s42;
	logic [41:0]        c_hl_s42;
	logic [14:0]        c_hh_s42;
	logic [L3_W-1:0]    l3_s43;
	logic [63:0]        d_ll_s44;
	logic [L3_W-1:0]    d_lh_s44;
	logic [39:0]        d_hl_s44;
	logic [22:0]        d_hh_s44;
	logic [CT_W-1:0]    ct_s45;
	logic [TERMS_W-1:0] terms_s46;
	logic [D_W-1:0]     d_s47;
	logic [UD_W-1:0]    ud_s48, num_s48;
	logic               ovf_c;

	// divider stages
	logic [UD_W-1:0] rem_s [0:Q_W];
	logic [UD_W-1:0] udv_s [0:Q_W-1];
	logic [Q_W-1:0]  q_s   [1:Q_W];

	logic [TEMP_W-1:0] temp_s67;
	logic              sat_s67;

	// ------------------------------------------------------------------
	// APB register file
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q <= RS_RESET;
			coef_a_q <= COEF_A_RESET;
			coef_b_q <= COEF_B_RESET;
			coef_c_q <= COEF_C_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:3])
				REG_SERIES: series_q <= pwdata[RS_W-1:0];
				REG_COEF_A: coef_a_q <= pwdata[COEF_W-1:0];
				REG_COEF_B: coef_b_q <= pwdata[COEF_W-1:0];
				REG_COEF_C: coef_c_q <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_SERIES: prdata = PDATA_W'(series_q);
			REG_COEF_A: prdata = PDATA_W'(coef_a_q);
			REG_COEF_B: prdata = PDATA_W'(coef_b_q);
			REG_COEF_C: prdata = PDATA_W'(coef_c_q);
			default:    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// global advance: hold everything while the result beat is stalled
	assign en         = ~(temp_valid & temp_stall);
	assign code_stall = ~en;

	// stage 1: capture code, flag the special cases
	assign code_m = raw_code & CODE_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			v_dly_s  <= '0;
		end else if (en) begin
			valid_s1 <= code_valid;
			valid_s2 <= valid_s1;
			v_dly_s  <= {v_dly_s[LOG_LAT-2:0], valid_s2};
		end
	end

	// stage 2: numerator Rs * (FS - code)
	assign diff_c = FULL_SCALE - CW'(code_s1);
	assign num_c  = NW'(series_q) * NW'(diff_c);

	always_ff @(posedge clk) begin
		if (en) begin
			code_s1  <= code_m;
			sp_s1    <= (code_m == '0) || (series_q == '0);
			num_s2   <= LOG_XW'(num_c);
			den_s2   <= LOG_XW'(code_s1);
			sp_s2    <= sp_s1;
			sp_dly_s <= {sp_dly_s[LOG_LAT-2:0], sp_s2};
		end
	end

	// log2 of numerator and code in parallel
	ntc_log2 u_log_num (
		.clk (clk),
		.en  (en),
		.x   (num_s2),
		.y   (ln_num)
	);

	ntc_log2 u_log_den (
		.clk (clk),
		.en  (en),
		.x   (den_s2),
		.y   (ln_den)
	);

	always_comb begin
		c36     = '0;
		c36.v   = v_dly_s[LOG_LAT-1];
		c36.sp  = sp_dly_s[LOG_LAT-1];
		c36.neg = ln_num < ln_den;
	end

	// overflow check: quotient would need more than Q_W bits
	assign ovf_c = CMP_W'(num_s48) >= (CMP_W'(ud_s48) << Q_W);

	// next flags: shift along, setting some on the way
	always_comb begin
		ctl_n[S_LOG+1] = c36;
		for (int k = S_LOG + 2; k <= S_OUT; k++) begin
			ctl_n[k] = ctl_s[k-1];
		end
		ctl_n[48].dz   = d_s47 == '0;
		ctl_n[48].dneg = d_s47[D_W-1];
		ctl_n[49].ovf  = ovf_c;
	end

	// control flags travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = S_LOG + 1; k <= S_OUT; k++) begin
				ctl_s[k] <= '0;
			end
		end else if (en) begin
			for (int k = S_LOG + 1; k <= S_OUT; k++) begin
				ctl_s[k] <= ctl_n[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// ln R, powers, and Steinhart-Hart terms
	always_ff @(posedge clk) begin
		if (en) begin
			// |log2 N - log2 code|
			mag_s37 <= (ln_num < ln_den) ? ln_den - ln_num : ln_num - ln_den;

			// times ln 2, split at bit 32
			lnh_s38 <= LOG_W'(mag_s37[LOG_W-1:32]) * LOG_W'(LN2_Q32);
			lnl_s38 <= 64'(mag_s37[31:0]) * 64'(LN2_Q32);

			lnr_s39 <= LNR_W'(lnh_s38 + LOG_W'(lnl_s38[63:32]));

			// partials of lnR^2 and B*lnR
			sq_ll_s40 <= 64'(lnr_s39[31:0]) * 64'(lnr_s39[31:0]);
			sq_lh_s40 <= LNR_W'(lnr_s39[31:0]) * LNR_W'(lnr_s39[LNR_W-1:32]);
			sq_hh_s40 <= 10'(lnr_s39[LNR_W-1:32]) * 10'(lnr_s39[LNR_W-1:32]);
			b_ll_s40  <= 64'(coef_b_q[31:0]) * 64'(lnr_s39[31:0]);
			b_lh_s40  <= LNR_W'(coef_b_q[31:0]) * LNR_W'(lnr_s39[LNR_W-1:32]);
			b_hl_s40  <= 40'(coef_b_q[COEF_W-1:32]) * 40'(lnr_s39[31:0]);
			b_hh_s40  <= 13'(coef_b_q[COEF_W-1:32]) * 13'(lnr_s39[LNR_W-1:32]);
			lnr_s40   <= lnr_s39;

			// lnR^2 and B*lnR, shifted right 32
			l2_s41  <= L2_W'((44'(sq_hh_s40) << 32) + (44'(sq_lh_s40) << 1)
			                 + 44'(sq_ll_s40[63:32]));
			bt_s41  <= BT_W'((48'(b_hh_s40) << 32) + 48'(b_lh_s40) + 48'(b_hl_s40)
			                 + 48'(b_ll_s40[63:32]));
			lnr_s41 <= lnr_s40;

			// partials of lnR^3
			c_ll_s42 <= 64'(l2_s41[31:0]) * 64'(lnr_s41[31:0]);
			c_lh_s42 <= LNR_W'(l2_s41[31:0]) * LNR_W'(lnr_s41[LNR_W-1:32]);
			c_hl_s42 <= 42'(l2_s41[L2_W-1:32]) * 42'(lnr_s41[31:0]);
			c_hh_s42 <= 15'(l2_s41[L2_W-1:32]) * 15'(lnr_s41[LNR_W-1:32]);
			bt_s42   <= bt_s41;

			l3_s43 <= L3_W'((50'(c_hh_s42) << 32) + 50'(c_lh_s42) + 50'(c_hl_s42)
			                + 50'(c_ll_s42[63:32]));
			bt_s43 <= bt_s42;

			// partials of C*lnR^3
			d_ll_s44 <= 64'(coef_c_q[31:0]) * 64'(l3_s43[31:0]);
			d_lh_s44 <= L3_W'(coef_c_q[31:0]) * L3_W'(l3_s43[L3_W-1:32]);
			d_hl_s44 <= 40'(coef_c_q[COEF_W-1:32]) * 40'(l3_s43[31:0]);
			d_hh_s44 <= 23'(coef_c_q[COEF_W-1:32]) * 23'(l3_s43[L3_W-1:32]);
			bt_s44   <= bt_s43;

			ct_s45 <= CT_W'((58'(d_hh_s44) << 32) + 58'(d_lh_s44) + 58'(d_hl_s44)
			                + 58'(d_ll_s44[63:32]));
			bt_s45 <= bt_s44;

			terms_s46 <= TERMS_W'(bt_s45) + TERMS_W'(ct_s45);

			// denominator, two's complement
			d_s47 <= ctl_s[46].neg ? D_W'(coef_a_q) - D_W'(terms_s46)
			                       : D_W'(coef_a_q) + D_W'(terms_s46);

			// dividend with half divisor for round-half-up
			ud_s48  <= d_s47[UD_W-1:0];
			num_s48 <= DIV_NUM + {1'b0, d_s47[UD_W-1:1]};

			rem_s[0] <= num_s48;
			udv_s[0] <= ud_s48;
		end
	end

	// ------------------------------------------------------------------
	// restoring divider, one quotient bit per stage, msb first
	for (genvar j = 1; j <= Q_W; j++) begin : g_div
		logic [CMP_W-1:0] trial;
		logic             ge;

		assign trial = CMP_W'(udv_s[j-1]) << (Q_W - j);
		assign ge    = CMP_W'(rem_s[j-1]) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? UD_W'(CMP_W'(rem_s[j-1]) - trial) : rem_s[j-1];
			end
		end

		if (j < Q_W) begin : g_ud
			always_ff @(posedge clk) begin
				if (en) begin
					udv_s[j] <= udv_s[j-1];
				end
			end
		end

		if (j == 1) begin : g_q0
			always_ff @(posedge clk) begin
				if (en) begin
					q_s[j] <= {{(Q_W-1){1'b0}}, ge};
				end
			end
		end else begin : g_qn
			always_ff @(posedge clk) begin
				if (en) begin
					q_s[j] <= {q_s[j-1][Q_W-2:0], ge};
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result register: special cases, saturation, offset to Celsius
	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_s[S_OUT-1].sp) begin
				temp_s67 <= T_MIN;
				sat_s67  <= 1'b0;
			end else if (ctl_s[S_OUT-1].dz) begin
				temp_s67 <= T_MAX;
				sat_s67  <= 1'b1;
			end else if (ctl_s[S_OUT-1].dneg) begin
				temp_s67 <= T_MIN;
				sat_s67  <= 1'b1;
			end else if (ctl_s[S_OUT-1].ovf || (q_s[Q_W] > Q_MAX)) begin
				temp_s67 <= T_MAX;
				sat_s67  <= 1'b1;
			end else begin
				temp_s67 <= TEMP_W'(q_s[Q_W]) - T_OFFSET;
				sat_s67  <= 1'b0;
			end
		end
	end

	assign temp_valid         = ctl_s[S_OUT].v;
	assign temp_centi_celsius = temp_s67;
	assign saturated          = sat_s67;

endmodule

`default_nettype wire
